// ----- rtl/core/idle_connection_reaper_queue_unit_assert.svh -----
// Assertion macros for the idle connection reaper queue unit
`ifndef IDLE_CONNECTION_REAPER_QUEUE_UNIT_ASSERT_SVH
`define IDLE_CONNECTION_REAPER_QUEUE_UNIT_ASSERT_SVH

// check a condition at every edge outside reset
`define ICRQ_ASSERT(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("icrq: invariant violated");

// check that the consequent holds in the same cycle
`define ICRQ_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("icrq: implication violated");

// check that the consequent holds in the next cycle
`define ICRQ_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("icrq: next-cycle implication violated");

`endif

// ----- rtl/core/icrq_pkg.sv -----
// Types and constants of the idle connection reaper queue
`timescale 1ns / 1ps

package icrq_pkg;

  localparam int unsigned OpW          = 2;
  localparam int unsigned ConnW        = 6;
  localparam int unsigned TimeW        = 32;
  localparam int unsigned TimeoutW     = 16;
  localparam int unsigned DefConnections = 64;
  localparam logic [TimeoutW-1:0] DefTimeout = 16'd15;

  typedef enum logic [OpW-1:0] {
    OP_TICK     = 2'd0,
    OP_ACTIVITY = 2'd1,
    OP_HANGUP   = 2'd2
  } op_e;

  typedef enum logic {
    CAUSE_TIMEOUT = 1'b0,
    CAUSE_HANGUP  = 1'b1
  } cause_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DL_RD = 4'b0010,
    S_CMP   = 4'b0100,
    S_LAST  = 4'b1000
  } state_e;

endpackage

// ----- rtl/core/icrq_in_if.sv -----
// Input channel: one event beat per handshake
`timescale 1ns / 1ps

interface icrq_in_if;
  import icrq_pkg::*;

  logic                valid;
  logic                ready;
  logic [OpW-1:0]      operation;
  logic [ConnW-1:0]    conn_id;
  logic                keep_open;

  modport source (output valid, operation, conn_id, keep_open, input ready);
  modport sink   (input valid, operation, conn_id, keep_open, output ready);
endinterface

// ----- rtl/core/icrq_out_if.sv -----
// Output channel: one close report beat per handshake
`timescale 1ns / 1ps

interface icrq_out_if;
  import icrq_pkg::*;

  logic                valid;
  logic                ready;
  logic [ConnW-1:0]    out_conn;
  logic                closed;
  logic                cause;
  logic                last;

  modport source (output valid, out_conn, closed, cause, last, input ready);
  modport sink   (input valid, out_conn, closed, cause, last, output ready);
endinterface

// ----- rtl/core/icrq_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module icrq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/idle_connection_reaper_queue_unit.sv -----
// Top level of the idle connection reaper queue
//
// in_i carries one event beat: tick, activity or hangup on a connection.
// out_o carries close reports: connection, closed flag, cause, last flag.
// cfg_we_i/cfg_wdata_i write the idle timeout in ticks; write only when idle.
// Activity and hangup are handled on the accepting edge; a hangup report lands
// in the output register on that edge and is visible the cycle after.
// A tick on an empty queue only advances the tick count. Otherwise it tests
// the head and pops each expired entry until an unexpired head or an empty
// queue: each pop reads the queue RAM, then the deadline RAM at the popped
// id, one registered read after the other. Each report is held one pop
// back so that the last flag is known before it is sent.
// in_i.ready is high only between ticks and while the output register is
// free or being emptied, so a stalled receiver holds the event side too and
// adds its stall cycles to a tick.
// Reset clears the tick count, alive flags and queue pointers and loads the
// timeout of 15; RAM contents stay undefined, no clearing pass is needed.
`timescale 1ns / 1ps
`include "idle_connection_reaper_queue_unit_assert.svh"

module idle_connection_reaper_queue_unit #(
  parameter int unsigned Connections = icrq_pkg::DefConnections
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [icrq_pkg::TimeoutW-1:0] cfg_wdata_i,
  icrq_in_if.sink                       in_i,
  icrq_out_if.source                    out_o
);
  import icrq_pkg::*;

  localparam int unsigned IdxW = $clog2(Connections);
  localparam int unsigned CntW = $clog2(Connections + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Connections - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Connections);
  localparam logic [ConnW:0]  ConnLim = (ConnW + 1)'(Connections);

  state_e              state_q, state_d;
  logic [TimeoutW-1:0] timeout_q;
  logic [TimeW-1:0]    now_q, now_d;
  logic [Connections-1:0] alive_q, alive_d;
  logic [IdxW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [IdxW-1:0]     id_q, id_d;

  logic                pend_valid_q, pend_valid_d;
  logic [IdxW-1:0]     pend_conn_q, pend_conn_d;
  logic                pend_closed_q, pend_closed_d;

  logic                out_valid_q;
  logic [ConnW-1:0]    out_conn_q, out_conn_d;
  logic                out_closed_q, out_closed_d;
  cause_e              out_cause_q, out_cause_d;
  logic                out_last_q, out_last_d;
  logic                out_load, out_free;

  logic                fifo_we, fifo_re;
  logic [IdxW-1:0]     fifo_waddr, fifo_wdata, fifo_raddr, fifo_rdata;
  logic                dl_we, dl_re;
  logic [IdxW-1:0]     dl_waddr, dl_raddr;
  logic [TimeW-1:0]    dl_wdata, dl_rdata;

  logic                in_fire, conn_ok, expired;
  logic [IdxW-1:0]     conn_idx, head_next;

  icrq_ram #(.Width(IdxW), .Depth(Connections)) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (fifo_waddr),
    .wdata_i (fifo_wdata),
    .re_i    (fifo_re),
    .raddr_i (fifo_raddr),
    .rdata_o (fifo_rdata)
  );

  icrq_ram #(.Width(TimeW), .Depth(Connections)) u_deadline_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (dl_waddr),
    .wdata_i (dl_wdata),
    .re_i    (dl_re),
    .raddr_i (dl_raddr),
    .rdata_o (dl_rdata)
  );

  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE) && out_free;
  assign in_fire     = in_i.valid && in_i.ready;
  assign conn_ok     = {1'b0, in_i.conn_id} < ConnLim;
  assign conn_idx    = in_i.conn_id[IdxW-1:0];
  assign head_next   = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign expired     = dl_rdata <= now_q;

  always_comb begin
    state_d       = state_q;
    now_d         = now_q;
    alive_d       = alive_q;
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    id_d          = id_q;
    pend_valid_d  = pend_valid_q;
    pend_conn_d   = pend_conn_q;
    pend_closed_d = pend_closed_q;
    out_load      = 1'b0;
    out_conn_d    = ConnW'(pend_conn_q);
    out_closed_d  = pend_closed_q;
    out_cause_d   = CAUSE_TIMEOUT;
    out_last_d    = 1'b0;
    fifo_we       = 1'b0;
    fifo_waddr    = tail_q;
    fifo_wdata    = conn_idx;
    fifo_re       = 1'b0;
    fifo_raddr    = head_q;
    dl_we         = 1'b0;
    dl_waddr      = conn_idx;
    dl_wdata      = now_q + (in_i.keep_open ? TimeW'(timeout_q) : '0);
    dl_re         = 1'b0;
    dl_raddr      = fifo_rdata;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (op_e'(in_i.operation))
            OP_TICK: begin
              now_d = now_q + 1'b1;
              if (count_q != '0) begin
                fifo_re = 1'b1;
                state_d = S_DL_RD;
              end
            end
            OP_ACTIVITY: begin
              if (conn_ok) begin
                dl_we = 1'b1;
                if (!alive_q[conn_idx] && count_q != Full) begin
                  fifo_we           = 1'b1;
                  tail_d            = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
                  count_d           = count_q + 1'b1;
                  alive_d[conn_idx] = 1'b1;
                end
              end
            end
            OP_HANGUP: begin
              if (conn_ok) begin
                alive_d[conn_idx] = 1'b0;
                out_load          = 1'b1;
                out_conn_d        = in_i.conn_id;
                out_closed_d      = 1'b1;
                out_cause_d       = CAUSE_HANGUP;
                out_last_d        = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_DL_RD: begin
        dl_re   = 1'b1;
        id_d    = fifo_rdata;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (!pend_valid_q || out_free) begin
          if (expired) begin
            out_load      = pend_valid_q;
            pend_valid_d  = 1'b1;
            pend_conn_d   = id_q;
            pend_closed_d = alive_q[id_q];
            alive_d[id_q] = 1'b0;
            head_d        = head_next;
            count_d       = count_q - 1'b1;
            if (count_q > CntW'(1)) begin
              fifo_re    = 1'b1;
              fifo_raddr = head_next;
              state_d    = S_DL_RD;
            end else begin
              state_d = S_LAST;
            end
          end else begin
            out_load     = pend_valid_q;
            out_last_d   = 1'b1;
            pend_valid_d = 1'b0;
            state_d      = S_IDLE;
          end
        end
      end
      S_LAST: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      timeout_q    <= DefTimeout;
      now_q        <= '0;
      alive_q      <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      now_q        <= now_d;
      alive_q      <= alive_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    id_q          <= id_d;
    pend_conn_q   <= pend_conn_d;
    pend_closed_q <= pend_closed_d;
    if (out_load) begin
      out_conn_q   <= out_conn_d;
      out_closed_q <= out_closed_d;
      out_cause_q  <= out_cause_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_conn = out_conn_q;
  assign out_o.closed   = out_closed_q;
  assign out_o.cause    = out_cause_q;
  assign out_o.last     = out_last_q;

  `ICRQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= Full)
  `ICRQ_ASSERT(a_ring_ptrs, clk_i, rst_ni, (head_q == tail_q) == (count_q == '0 || count_q == Full))
  `ICRQ_ASSERT_IMP(a_pend_not_stranded, clk_i, rst_ni, pend_valid_q, state_q != S_IDLE)
  `ICRQ_ASSERT_NXT(a_last_ends_item, clk_i, rst_ni, out_load && out_last_d, state_q == S_IDLE)

endmodule

// ----- tb/sv/icrq_close_checker.sv -----
// Checker that predicts and compares the close reports of the reaper queue
`timescale 1ns / 1ps

module icrq_close_checker
  import icrq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TimeoutW-1:0] cfg_wdata_i,
  icrq_in_if                  evt_i,
  icrq_out_if                 rpt_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  localparam int unsigned Conns       = DefConnections;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [ConnW-1:0] conn;
    logic             closed;
    cause_e           cause;
    logic             last;
  } close_rpt_t;

  close_rpt_t          due_closes[$];
  logic [TimeW-1:0]    tick_now;
  logic [TimeoutW-1:0] idle_timeout;
  logic [Conns-1:0]    conn_alive;
  logic [TimeW-1:0]    conn_deadline [Conns];
  logic [ConnW-1:0]    reap_ring [Conns];
  logic [ConnW-1:0]    ring_head;
  logic [ConnW-1:0]    ring_tail;
  logic [ConnW:0]      ring_fill;
  int unsigned         fail_count;
  int unsigned         pending;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  task automatic reap_event(logic [OpW-1:0] op, logic [ConnW-1:0] conn, logic keep);
    logic [ConnW-1:0] id;
    int unsigned      pops;
    close_rpt_t       rpt;
    pops = 0;
    case (op)
      OP_TICK: begin
        tick_now = tick_now + 1;
        while (ring_fill != 0) begin
          id = reap_ring[ring_head];
          if (conn_deadline[id] > tick_now) break;
          ring_head = ring_head + 1'b1;
          ring_fill = ring_fill - 1'b1;
          rpt = '{conn: id, closed: conn_alive[id], cause: CAUSE_TIMEOUT, last: 1'b0};
          due_closes.push_back(rpt);
          conn_alive[id] = 1'b0;
          pops++;
        end
        if (pops != 0) begin
          rpt = due_closes.pop_back();
          rpt.last = 1'b1;
          due_closes.push_back(rpt);
        end
      end
      OP_ACTIVITY: begin
        if (int'(conn) < Conns) begin
          conn_deadline[conn] = keep ? tick_now + {16'd0, idle_timeout} : tick_now;
          if (!conn_alive[conn] && ring_fill < Conns) begin
            reap_ring[ring_tail] = conn;
            ring_tail = ring_tail + 1'b1;
            ring_fill = ring_fill + 1'b1;
            conn_alive[conn] = 1'b1;
          end
        end
      end
      OP_HANGUP: begin
        if (int'(conn) < Conns) begin
          conn_alive[conn] = 1'b0;
          rpt = '{conn: conn, closed: 1'b1, cause: CAUSE_HANGUP, last: 1'b1};
          due_closes.push_back(rpt);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_close();
    close_rpt_t want;
    if (due_closes.size() == 0) begin
      fail_count++;
      if (fail_count <= ReportLimit)
        $display("%0t: unexpected close report conn %0d closed %0b cause %0b last %0b",
                 $realtime, rpt_i.out_conn, rpt_i.closed, rpt_i.cause, rpt_i.last);
    end else begin
      want = due_closes.pop_front();
      if (rpt_i.out_conn !== want.conn || rpt_i.closed !== want.closed ||
          rpt_i.cause !== want.cause || rpt_i.last !== want.last) begin
        fail_count++;
        if (fail_count <= ReportLimit)
          $display("%0t: close report mismatch: expected conn %0d closed %0b cause %0b last %0b, got conn %0d closed %0b cause %0b last %0b",
                   $realtime, want.conn, want.closed, want.cause, want.last,
                   rpt_i.out_conn, rpt_i.closed, rpt_i.cause, rpt_i.last);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_closes.delete();
      tick_now     = '0;
      idle_timeout = DefTimeout;
      conn_alive   = '0;
      ring_head    = '0;
      ring_tail    = '0;
      ring_fill    = '0;
      fail_count   = 0;
      pending      = 0;
    end else begin
      if (rpt_i.valid && rpt_i.ready) check_close();
      if (evt_i.valid && evt_i.ready) reap_event(evt_i.operation, evt_i.conn_id, evt_i.keep_open);
      if (cfg_we_i) idle_timeout = cfg_wdata_i;
      pending = due_closes.size();
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// Top of the reaper queue testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
  import icrq_pkg::*;

  localparam logic [OpW-1:0] OpReserved = 2'd3;
  localparam int unsigned Conns        = DefConnections;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned PhaseBeats   = 28;
  localparam int unsigned Phases       = 8;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [TimeoutW-1:0] cfg_wdata;
  int unsigned         src_idle_pct   = 0;
  int unsigned         sink_stall_pct = 0;
  int unsigned         idle_cycles    = 0;
  int unsigned         fail_count;
  int unsigned         pending;

  icrq_in_if  evt_if ();
  icrq_out_if rpt_if ();

  idle_connection_reaper_queue_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (evt_if),
    .out_o       (rpt_if)
  );

  icrq_close_checker close_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .evt_i        (evt_if),
    .rpt_i        (rpt_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    rpt_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (evt_if.valid && evt_if.ready) || (rpt_if.valid && rpt_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic send_beat(logic [OpW-1:0] op, logic [ConnW-1:0] conn, logic keep);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      evt_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    evt_if.valid     <= 1'b1;
    evt_if.operation <= op;
    evt_if.conn_id   <= conn;
    evt_if.keep_open <= keep;
    do @(posedge clk_i); while (!evt_if.ready);
  endtask

  // hold the sender until every close has arrived and the block is idle
  task automatic drain();
    @(negedge clk_i);
    evt_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_timeout(logic [TimeoutW-1:0] ticks);
    drain();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [OpW-1:0]      op;
    logic [TimeoutW-1:0] ticks;
    int unsigned         r;
    int unsigned         beats;
    int unsigned         c;

    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    evt_if.valid     = 1'b0;
    evt_if.operation = OP_TICK;
    evt_if.conn_id   = '0;
    evt_if.keep_open = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_beat(OP_TICK,     6'd63, 1'b1);
    send_beat(OP_ACTIVITY, 6'd0,  1'b1);
    send_beat(OP_ACTIVITY, 6'd63, 1'b1);
    send_beat(OP_HANGUP,   6'd42, 1'b0);
    send_beat(OP_HANGUP,   6'd63, 1'b1);
    send_beat(OpReserved,  6'd63, 1'b1);
    send_beat(OP_TICK,     6'd0,  1'b0);
    send_beat(OP_ACTIVITY, 6'd63, 1'b0);
    send_beat(OP_ACTIVITY, 6'd0,  1'b0);
    send_beat(OP_TICK,     6'd21, 1'b1);
    send_beat(OP_ACTIVITY, 6'd5,  1'b1);
    send_beat(OP_ACTIVITY, 6'd6,  1'b0);
    send_beat(OP_TICK,     6'd0,  1'b0);
    send_beat(OP_HANGUP,   6'd5,  1'b0);
    send_beat(OP_ACTIVITY, 6'd5,  1'b0);
    send_beat(OP_TICK,     6'd0,  1'b0);

    for (int phase = 0; phase < Phases; phase++) begin
      case (phase)
        0:       ticks = 16'd0;
        1:       ticks = 16'd3;
        2:       ticks = 16'd1;
        3:       ticks = 16'($urandom_range(20));
        4:       ticks = 16'd15;
        5:       ticks = 16'd2;
        6:       ticks = 16'($urandom_range(8));
        default: ticks = 16'hFFFF;
      endcase
      write_timeout(ticks);
      case (phase % 4)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 65; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 65; end
        default: begin src_idle_pct = 21; sink_stall_pct = 21; end
      endcase

      // fill the ring, then refuse a re-activated connection and expire the lot
      if (phase == 0) begin
        for (c = 0; c < Conns; c++) send_beat(OP_ACTIVITY, ConnW'(c), 1'($urandom_range(1)));
        c = $urandom_range(Conns - 1);
        send_beat(OP_HANGUP, ConnW'(c), 1'b0);
        send_beat(OP_ACTIVITY, ConnW'(c), 1'b1);
        send_beat(OP_TICK, '0, 1'b0);
      end

      beats = 0;
      while (beats < PhaseBeats) begin
        r  = $urandom_range(99);
        op = (r < 35) ? OP_TICK : (r < 80) ? OP_ACTIVITY : (r < 95) ? OP_HANGUP : OpReserved;
        send_beat(op,
                  ($urandom_range(9) < 7) ? ConnW'($urandom_range(7)) : ConnW'($urandom_range(63)),
                  1'($urandom_range(1)));
        if (op != OpReserved) beats++;
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/icrq_pkg.sv
rtl/core/icrq_in_if.sv
rtl/core/icrq_out_if.sv
rtl/core/icrq_ram.sv
rtl/core/idle_connection_reaper_queue_unit.sv
tb/sv/icrq_close_checker.sv
tb/sv/tb.sv
